### hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared macros for concurrent assertions on a clock and an active-low reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Asserts that a property holds at every rising clock edge outside reset.
`define CHK_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// Asserts that a condition is never true at a rising clock edge outside reset.
`define CHK_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`endif

### hw/rtl/crc32pc_pkg.sv
// ---------------------------------------------------------------------------
// CRC-32 packet checker package
// Types, codes, widths and the byte-wide CRC-32 update shared by the design.
// ---------------------------------------------------------------------------
package crc32pc_pkg;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

	// A packet needs this many trailing bytes to carry its CRC.
	localparam logic [2:0] TAIL_LEN = 3'd4;

	localparam int PPW_W    = 16;
	localparam int THR_W    = 17;
	localparam int CNT_W    = 16;
	localparam int MODE_W   = 2;
	localparam int CFG_IDX_W = 2;

	localparam logic [PPW_W-1:0]  PPW_RESET = 16'd100;
	localparam logic [THR_W-1:0]  THR_RESET = 17'd32768;
	localparam logic [MODE_W-1:0] TOP_MODE  = 2'd3;

	typedef enum logic {
		FUNC_BYTE     = 1'b0,
		FUNC_MODE_REQ = 1'b1
	} func_t;

	typedef enum logic {
		KIND_VERDICT = 1'b0,
		KIND_REPLY   = 1'b1
	} result_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PKTS_PER_WINDOW = 2'd0,
		CFG_THRESHOLD_MODE1 = 2'd1,
		CFG_THRESHOLD_MODE2 = 2'd2,
		CFG_THRESHOLD_MODE3 = 2'd3
	} cfg_reg_t;

	// What the packet stage hands to the window stage for one transaction.
	typedef struct packed {
		logic              func;
		logic              last;
		logic [MODE_W-1:0] req;
		logic              crc_ok;
		logic              too_short;
	} pkt_result_t;

	// One byte of the reflected CRC-32, as an XOR network of eight bit steps.
	function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

### hw/rtl/crc32_packet_check_rate_fallback_core.sv
// ---------------------------------------------------------------------------
// CRC-32 packet checker with pass-rate mode fallback
// Checks the trailing CRC-32 of byte-serial packets, tracks the pass rate per
// window, steps the operating mode down after two low windows in a row and answers mode requests.
// ---------------------------------------------------------------------------
// A transaction passes the input register, the packet stage and the result
// register in turn. Throughput: one transaction per cycle while the output
// is not stalled, set by this three-register pipeline with no internal loops.
// Reset: arst_n clears all control state, counters, CRC state and the
// configuration registers to their defaults at once; no clearing pass.
module crc32_packet_check_rate_fallback_core import crc32pc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// Input channel.
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 func,
	input  logic [7:0]           data_byte,
	input  logic                 last,
	input  logic [MODE_W-1:0]    requested_mode,
	// Result channel.
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 result_kind,
	output logic                 crc_ok,
	output logic                 too_short,
	output logic                 index_valid,
	output logic [MODE_W-1:0]    mode_index,
	// Configuration write channel.
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [THR_W-1:0]     cfg_data
);

	// -----------------------------------------------------------------------
	// Configuration registers. Writes are always taken; the user must issue them only
	// while the pipeline is empty, so no item sees a half-written setup; the block does not check this.
	// -----------------------------------------------------------------------
	logic [PPW_W-1:0] ppw_q;
	logic [THR_W-1:0] thr1_q;
	logic [THR_W-1:0] thr2_q;
	logic [THR_W-1:0] thr3_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppw_q  <= PPW_RESET;
			thr1_q <= THR_RESET;
			thr2_q <= THR_RESET;
			thr3_q <= THR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_PKTS_PER_WINDOW: ppw_q  <= cfg_data[PPW_W-1:0];
				CFG_THRESHOLD_MODE1: thr1_q <= cfg_data;
				CFG_THRESHOLD_MODE2: thr2_q <= cfg_data;
				CFG_THRESHOLD_MODE3: thr3_q <= cfg_data;
			endcase
		end
	end

	// -----------------------------------------------------------------------
	// Pipeline handshake. Each stage advances when the one after it has room
	// or is moving on in the same cycle. Only mode requests and last bytes
	// produce a result; other bytes retire from stage 2 without one.
	// -----------------------------------------------------------------------
	logic              valid_s1;
	logic              func_s1;
	logic [7:0]        byte_s1;
	logic              last_s1;
	logic [MODE_W-1:0] req_s1;

	logic              valid_s2;
	pkt_result_t       pkt_s2;
	pkt_result_t       pkt_next;

	logic              out_valid_q;
	logic              out_free;
	logic              s2_has_result;
	logic              fire_s2;
	logic              load_out;
	logic              s2_free;
	logic              fire_s1;
	logic              s1_free;

	assign out_free      = !out_valid_q || out_ready;
	assign s2_has_result = (pkt_s2.func == FUNC_MODE_REQ) || pkt_s2.last;
	assign fire_s2       = valid_s2 && (!s2_has_result || out_free);
	assign load_out      = fire_s2 && s2_has_result;
	assign s2_free       = !valid_s2 || fire_s2;
	assign fire_s1       = valid_s1 && s2_free;
	assign s1_free       = !valid_s1 || fire_s1;
	assign in_ready      = s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1 <= in_valid;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
			if (out_free) begin
				out_valid_q <= load_out;
			end
		end
	end

	// Input register: payload only, qualified by valid_s1.
	always_ff @(posedge clk) begin
		if (s1_free) begin
			func_s1 <= func;
			byte_s1 <= data_byte;
			last_s1 <= last;
			req_s1  <= requested_mode;
		end
	end

	// -----------------------------------------------------------------------
	// Stage 1: packet state. The CRC runs four bytes behind the input: the
	// byte leaving the four-byte tail window is folded into the CRC, so that
	// on the last byte the window holds exactly the transmitted CRC word in
	// little-endian order.
	// -----------------------------------------------------------------------
	logic [31:0] crc_q;
	logic [31:0] tail_q;
	logic [2:0]  seen_q;
	logic [31:0] crc_upd;
	logic [31:0] tail_upd;
	logic [2:0]  seen_upd;
	logic        short_c;
	logic        ok_c;
	logic        byte_fire;

	assign crc_upd   = (seen_q >= TAIL_LEN) ? crc_byte(crc_q, tail_q[7:0]) : crc_q;
	assign tail_upd  = {byte_s1, tail_q[31:8]};
	assign seen_upd  = (seen_q < TAIL_LEN) ? seen_q + 3'd1 : seen_q;
	assign short_c   = seen_upd < TAIL_LEN;
	assign ok_c      = !short_c && ((~crc_upd) == tail_upd);
	assign byte_fire = fire_s1 && (func_s1 == FUNC_BYTE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= CRC_INIT;
			tail_q <= '0;
			seen_q <= '0;
		end else if (byte_fire) begin
			if (last_s1) begin
				// The packet is closed; start the next one from scratch.
				crc_q  <= CRC_INIT;
				tail_q <= '0;
				seen_q <= '0;
			end else begin
				crc_q  <= crc_upd;
				tail_q <= tail_upd;
				seen_q <= seen_upd;
			end
		end
	end

	always_comb begin
		pkt_next.func      = func_s1;
		pkt_next.last      = last_s1;
		pkt_next.req       = req_s1;
		pkt_next.crc_ok    = ok_c;
		pkt_next.too_short = short_c;
	end

	always_ff @(posedge clk) begin
		if (s2_free) begin
			pkt_s2 <= pkt_next;
		end
	end

	// -----------------------------------------------------------------------
	// Stage 2: window statistics and mode control. A window is low when
	// pass * 2^16 < threshold * total, compared exactly: the product is
	// 17 by 16 bits and the left side is the pass count shifted by 16.
	// -----------------------------------------------------------------------
	logic [CNT_W-1:0]  pass_q;
	logic [CNT_W-1:0]  total_q;
	logic [MODE_W-1:0] mode_q;
	logic [MODE_W-1:0] cap_q;
	logic              streak_q;

	logic [CNT_W-1:0]  total_inc;
	logic [CNT_W-1:0]  pass_inc;
	logic              window_end;
	logic [THR_W-1:0]  thr_sel;
	logic [32:0]       rhs;
	logic [32:0]       lhs;
	logic              is_low;
	logic              eval;
	logic              drop;
	logic              is_req;
	logic [MODE_W-1:0] mode_dec;
	logic [MODE_W-1:0] reply_idx;

	assign is_req     = pkt_s2.func == FUNC_MODE_REQ;
	assign total_inc  = total_q + CNT_W'(1);
	assign pass_inc   = pass_q + CNT_W'(pkt_s2.crc_ok);
	// A window size of zero closes a window with every packet.
	assign window_end = total_inc >= ppw_q;

	always_comb begin
		unique case (mode_q)
			2'd0: thr_sel = '0;
			2'd1: thr_sel = thr1_q;
			2'd2: thr_sel = thr2_q;
			2'd3: thr_sel = thr3_q;
		endcase
	end

	assign rhs       = 33'(thr_sel) * 33'(total_inc);
	assign lhs       = {1'b0, pass_inc, 16'd0};
	assign is_low    = lhs < rhs;
	// Mode zero has no threshold: the window closes but nothing else moves.
	assign eval      = window_end && (mode_q != 2'd0);
	assign drop      = eval && is_low && streak_q;
	assign mode_dec  = mode_q - 2'd1;
	assign reply_idx = (pkt_s2.req <= cap_q) ? pkt_s2.req : cap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_q   <= '0;
			total_q  <= '0;
			mode_q   <= '0;
			cap_q    <= TOP_MODE;
			streak_q <= 1'b0;
		end else if (load_out) begin
			if (is_req) begin
				// The request is stored as given; only the reply is capped.
				mode_q <= pkt_s2.req;
			end else begin
				if (window_end) begin
					pass_q  <= '0;
					total_q <= '0;
				end else begin
					pass_q  <= pass_inc;
					total_q <= total_inc;
				end
				if (eval) begin
					if (is_low) begin
						if (streak_q) begin
							streak_q <= 1'b0;
							mode_q   <= mode_dec;
							cap_q    <= mode_dec;
						end else begin
							streak_q <= 1'b1;
						end
					end else begin
						streak_q <= 1'b0;
					end
				end
			end
		end
	end

	// -----------------------------------------------------------------------
	// Result register. It holds a finished result while the stages behind it keep
	// taking new transactions, until one that produces a result reaches stage 2.
	// -----------------------------------------------------------------------
	logic              kind_q;
	logic              ok_q;
	logic              short_q;
	logic              ivalid_q;
	logic [MODE_W-1:0] idx_q;

	always_ff @(posedge clk) begin
		if (load_out) begin
			if (is_req) begin
				kind_q   <= KIND_REPLY;
				ok_q     <= 1'b0;
				short_q  <= 1'b0;
				ivalid_q <= 1'b1;
				idx_q    <= reply_idx;
			end else begin
				kind_q   <= KIND_VERDICT;
				ok_q     <= pkt_s2.crc_ok;
				short_q  <= pkt_s2.too_short;
				ivalid_q <= drop;
				idx_q    <= drop ? mode_dec : '0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign result_kind = kind_q;
	assign crc_ok      = ok_q;
	assign too_short   = short_q;
	assign index_valid = ivalid_q;
	assign mode_index  = idx_q;

endmodule

### hw/rtl/crc32pc_checker.sv
// ---------------------------------------------------------------------------
// CRC-32 packet checker port assertions
// Watches the top level's ports for malformed results and stalls.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module crc32pc_port_assert import crc32pc_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic              result_kind,
	input logic              crc_ok,
	input logic              too_short,
	input logic              index_valid,
	input logic [MODE_W-1:0] mode_index
);

	// A mode reply always carries an index and never a packet verdict.
	`CHK_ASSERT(a_reply_form, clk, arst_n,
		(out_valid && result_kind == KIND_REPLY) |-> (index_valid && !crc_ok && !too_short),
		"mode reply has wrong form")

	// A short packet can never pass its CRC check.
	`CHK_NEVER(a_short_not_ok, clk, arst_n, out_valid && too_short && crc_ok,
		"short packet reported as passing")

	// Without an index report the index field reads zero.
	`CHK_NEVER(a_idx_zero, clk, arst_n, out_valid && !index_valid && mode_index != 2'd0,
		"mode index set without report")

	// The input side only stalls when the whole pipeline is backed up by the output.
	`CHK_ASSERT(a_stall_cause, clk, arst_n, !in_ready |-> (out_valid && !out_ready),
		"input stalled without output backpressure")

	// A stalled result holds.
	`CHK_ASSERT(a_out_hold, clk, arst_n,
		(out_valid && !out_ready) |=>
			(out_valid && $stable(result_kind) && $stable(crc_ok) && $stable(mode_index)),
		"stalled result changed")

endmodule

bind crc32_packet_check_rate_fallback_core crc32pc_port_assert u_crc32pc_port_assert (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.result_kind (result_kind),
	.crc_ok      (crc_ok),
	.too_short   (too_short),
	.index_valid (index_valid),
	.mode_index  (mode_index)
);
